// File: src/gtfw_pkg.sv
// ----------------------------------------------------------------------------
// gtfw_pkg
// Shared types, codes and the 5x7 font table for the glyph text writer.
// ----------------------------------------------------------------------------
package gtfw_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // cursor motion
  localparam int ADVANCE    = 6;
  localparam int LINE_STEP  = 8;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;

  // one glyph, column 0 first, row 0 in bit 0
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        start_text;
    logic [6:0]  start_x;
    logic [5:0]  start_y;
    logic [7:0]  char_code;
    logic [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [6:0]  cursor_col;
    logic [6:0]  cursor_row;
  } out_item_t;

  function automatic glyph_t glyph_pack(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] b4);
    glyph_t g;
    g[0] = b0[GLYPH_ROWS-1:0];
    g[1] = b1[GLYPH_ROWS-1:0];
    g[2] = b2[GLYPH_ROWS-1:0];
    g[3] = b3[GLYPH_ROWS-1:0];
    g[4] = b4[GLYPH_ROWS-1:0];
    return g;
  endfunction

  // font lookup; codes without a glyph (and codes outside space..'z') are blank
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    case (code)
      "!":     g = glyph_pack(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
      "%":     g = glyph_pack(8'h43, 8'h4D, 8'h52, 8'h54, 8'h42);
      "+":     g = glyph_pack(8'h00, 8'h08, 8'h3E, 8'h08, 8'h00);
      ".":     g = glyph_pack(8'h00, 8'h00, 8'h00, 8'h60, 8'h00);
      "/":     g = glyph_pack(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      "0":     g = glyph_pack(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      "1":     g = glyph_pack(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      "2":     g = glyph_pack(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      "3":     g = glyph_pack(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      "4":     g = glyph_pack(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      "5":     g = glyph_pack(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      "6":     g = glyph_pack(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      "7":     g = glyph_pack(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      "8":     g = glyph_pack(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      "9":     g = glyph_pack(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      ":":     g = glyph_pack(8'h00, 8'h00, 8'h0C, 8'h00, 8'h00);
      "=":     g = glyph_pack(8'h00, 8'h18, 8'h18, 8'h18, 8'h00);
      "A":     g = glyph_pack(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      "B":     g = glyph_pack(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      "C":     g = glyph_pack(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      "D":     g = glyph_pack(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      "E":     g = glyph_pack(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      "F":     g = glyph_pack(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      "G":     g = glyph_pack(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      "H":     g = glyph_pack(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      "I":     g = glyph_pack(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      "J":     g = glyph_pack(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      "K":     g = glyph_pack(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      "L":     g = glyph_pack(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      "M":     g = glyph_pack(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      "N":     g = glyph_pack(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      "O":     g = glyph_pack(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      "P":     g = glyph_pack(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      "Q":     g = glyph_pack(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      "R":     g = glyph_pack(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      "S":     g = glyph_pack(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      "T":     g = glyph_pack(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      "U":     g = glyph_pack(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      "V":     g = glyph_pack(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      "W":     g = glyph_pack(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      "X":     g = glyph_pack(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      "Y":     g = glyph_pack(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      "Z":     g = glyph_pack(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      "a":     g = glyph_pack(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
      "b":     g = glyph_pack(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
      "c":     g = glyph_pack(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
      "d":     g = glyph_pack(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
      "e":     g = glyph_pack(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
      "f":     g = glyph_pack(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
      "g":     g = glyph_pack(8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E);
      "h":     g = glyph_pack(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
      "i":     g = glyph_pack(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
      "j":     g = glyph_pack(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
      "k":     g = glyph_pack(8'h7F, 8'h10, 8'h28, 8'h44, 8'h00);
      "l":     g = glyph_pack(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
      "m":     g = glyph_pack(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
      "n":     g = glyph_pack(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
      "o":     g = glyph_pack(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
      "p":     g = glyph_pack(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08);
      "q":     g = glyph_pack(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C);
      "r":     g = glyph_pack(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
      "s":     g = glyph_pack(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
      "t":     g = glyph_pack(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
      "u":     g = glyph_pack(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
      "v":     g = glyph_pack(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
      "w":     g = glyph_pack(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
      "x":     g = glyph_pack(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
      "y":     g = glyph_pack(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
      "z":     g = glyph_pack(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: src/gtfw_chan_if.sv
// ----------------------------------------------------------------------------
// gtfw_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface gtfw_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/glyph_text_framebuffer_writer_core.sv
// ----------------------------------------------------------------------------
// glyph_text_framebuffer_writer_core
// 5x7 text renderer into a page-organized monochrome framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per beat: draw a character at the text cursor
//   (optionally loading the cursor from start_x/start_y first), clear the
//   framebuffer, or read one framebuffer byte. rsp returns one beat per item
//   with the read byte (zero unless a read) and the cursor after the item.
//   Items are handled one at a time; req.ready is high only while idle.
//   A draw runs, after the accepting idle cycle, ten
//   read-modify-write slots (five glyph columns, two page bytes each) through
//   the shared pixel unit and the framebuffer RAM, then finishes the last
//   write and posts the result. A read passes ST_READ and ST_READ_WAIT
//   (registered RAM read). A clear sweeps the RAM one byte per cycle over all
//   PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes (1024 at the defaults).
//   After reset the same clearing sweep runs before the first item is taken.
//   The result sits in an output register; when rsp is stalled, a finished
//   item waits for that register to drain before the block goes idle.
// ----------------------------------------------------------------------------
module glyph_text_framebuffer_writer_core
  import gtfw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input logic        clk,
  input logic        rst,
  gtfw_chan_if.sink   req,
  gtfw_chan_if.source rsp
);
  localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int COL_W       = $clog2(PANEL_WIDTH + 134);
  localparam int ROW_W       = $clog2(PANEL_HEIGHT + 72);
  localparam int CMP_W       = ((ADDR_W > 10) ? ADDR_W : 10) + 1;
  localparam int LAST_SLOT   = 2 * GLYPH_COLS - 1;

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_DRAW      = 7'b0000100,
    ST_DRAW_END  = 7'b0001000,
    ST_READ      = 7'b0010000,
    ST_READ_WAIT = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [3:0]        slot;
  glyph_t            glyph;
  logic [COL_W-1:0]  text_col;
  logic [ROW_W-1:0]  text_row;
  logic [ADDR_W-1:0] rd_index;
  logic              rd_ok;
  logic [7:0]        res_data;
  logic              rsp_valid;
  out_item_t         rsp_item;

  // write-back stage of the read-modify-write
  logic              wb_valid;
  logic              wb_en;
  logic [ADDR_W-1:0] wb_addr;
  logic [7:0]        wb_bits;

  logic [ADDR_W-1:0] unit_addr;
  logic [7:0]        unit_bits;
  logic              unit_en;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              accept;
  logic              rsp_free;
  logic [COL_W-1:0]  col_adv;
  logic [ROW_W-1:0]  row_adv;

  assign accept   = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;

  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_item;

  // shared pixel unit, one glyph column half per slot
  gtfw_pixel_unit #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_pixel (
    .col      (text_col),
    .row      (text_row),
    .col_idx  (slot[3:1]),
    .half     (slot[0]),
    .bits     (glyph[slot[3:1]]),
    .addr     (unit_addr),
    .set_bits (unit_bits),
    .en       (unit_en)
  );

  // framebuffer memory ports
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = wb_valid && wb_en;
      ram_waddr = wb_addr;
      ram_wdata = ram_rdata | wb_bits;
    end
  end

  assign ram_raddr = (state == ST_READ) ? rd_index : unit_addr;

  gtfw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_fb_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cursor advance after a draw
  assign col_adv = text_col + COL_W'(ADVANCE);
  assign row_adv = text_row + ROW_W'(LINE_STEP);

  // write-back stage follows each draw slot in the next cycle
  always_ff @(posedge clk) begin
    wb_addr <= unit_addr;
    wb_bits <= unit_bits;
    wb_en   <= unit_en;
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= (state == ST_DRAW);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      slot      <= '0;
      text_col  <= '0;
      text_row  <= '0;
      res_data  <= 8'h00;
      rd_ok     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
            clr_addr <= '0;
            state    <= ST_DONE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_data <= 8'h00;
            slot     <= '0;
            glyph    <= glyph_lookup(req.payload.char_code);
            rd_index <= ADDR_W'(req.payload.read_index);
            rd_ok    <= CMP_W'(req.payload.read_index) < CMP_W'(STORE_BYTES);
            case (req.payload.kind)
              KIND_DRAW: begin
                if (req.payload.start_text) begin
                  text_col <= COL_W'(req.payload.start_x);
                  text_row <= ROW_W'(req.payload.start_y);
                end
                state <= ST_DRAW;
              end
              KIND_CLEAR: state <= ST_CLEAR;
              KIND_READ:  state <= ST_READ;
              default:    state <= ST_DONE;
            endcase
          end
        end
        ST_DRAW: begin
          if (slot == 4'(LAST_SLOT)) begin
            state <= ST_DRAW_END;
          end else begin
            slot <= slot + 4'd1;
          end
        end
        ST_DRAW_END: begin
          if (col_adv > COL_W'(PANEL_WIDTH - ADVANCE)) begin
            text_col <= '0;
            text_row <= (row_adv > ROW_W'(PANEL_HEIGHT)) ? ROW_W'(PANEL_HEIGHT) : row_adv;
          end else begin
            text_col <= col_adv;
          end
          state <= ST_DONE;
        end
        ST_READ: begin
          state <= ST_READ_WAIT;
        end
        ST_READ_WAIT: begin
          res_data <= rd_ok ? ram_rdata : 8'h00;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // the clearing sweep after reset has no item behind it
          if (!wb_valid && rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // post-reset sweep ends without a result beat
  logic item_live;
  always_ff @(posedge clk) begin
    if (rst) begin
      item_live <= 1'b0;
    end else if (accept) begin
      item_live <= 1'b1;
    end else if (state == ST_DONE && rsp_free) begin
      item_live <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free && item_live) begin
      rsp_item.read_data  <= res_data;
      rsp_item.cursor_col <= text_col[6:0];
      rsp_item.cursor_row <= text_row[6:0];
    end
  end

  // result beat valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && rsp_free && item_live) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // no framebuffer write while a read item is in flight
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_READ_WAIT) |-> !ram_we)
    else $error("framebuffer written during a read item");

  // a finished draw leaves the cursor inside the usable columns
  a_col_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_END) |=> (text_col <= COL_W'(PANEL_WIDTH - ADVANCE)))
    else $error("cursor column not wrapped after draw");

  // an accepted item always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted item did not start");
`endif
endmodule

// File: src/gtfw_ram.sv
// ----------------------------------------------------------------------------
// gtfw_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gtfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// File: src/gtfw_pixel_unit.sv
// ----------------------------------------------------------------------------
// gtfw_pixel_unit
// Maps one glyph column half onto a framebuffer byte: address, bits, clipping.
// ----------------------------------------------------------------------------
module gtfw_pixel_unit
  import gtfw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64,
  localparam int PAGES       = (PANEL_HEIGHT + 7) / 8,
  localparam int STORE_BYTES = PANEL_WIDTH * PAGES,
  localparam int ADDR_W      = $clog2(STORE_BYTES),
  localparam int COL_W       = $clog2(PANEL_WIDTH + 134),
  localparam int ROW_W       = $clog2(PANEL_HEIGHT + 72)
) (
  input  logic [COL_W-1:0]      col,
  input  logic [ROW_W-1:0]      row,
  input  logic [2:0]            col_idx,
  input  logic                  half,
  input  logic [GLYPH_ROWS-1:0] bits,
  output logic [ADDR_W-1:0]     addr,
  output logic [7:0]            set_bits,
  output logic                  en
);
  localparam int PG_W       = ROW_W - 2;
  localparam int SUM_W      = PG_W + $clog2(PANEL_WIDTH + 1) + 1;
  localparam int FULL_PAGES = PANEL_HEIGHT / 8;
  localparam logic [7:0] PART_MASK = 8'((1 << (PANEL_HEIGHT % 8)) - 1);

  logic [COL_W-1:0] px;
  logic [PG_W-1:0]  page;
  logic [14:0]      shifted;
  logic [7:0]       raw_bits;
  logic [7:0]       row_mask;
  logic [SUM_W-1:0] addr_full;

  // pixel column and page touched by this half
  assign px   = col + COL_W'(col_idx);
  assign page = PG_W'(row >> 3) + PG_W'(half);

  // glyph column moved to the row offset inside the page
  assign shifted  = {8'b0, bits} << row[2:0];
  assign raw_bits = half ? {1'b0, shifted[14:8]} : shifted[7:0];

  // rows below the panel bottom are clipped
  always_comb begin
    if (page < PG_W'(FULL_PAGES)) begin
      row_mask = 8'hFF;
    end else if (page == PG_W'(FULL_PAGES)) begin
      row_mask = PART_MASK;
    end else begin
      row_mask = 8'h00;
    end
  end

  assign set_bits  = raw_bits & row_mask;
  assign en        = (px < COL_W'(PANEL_WIDTH)) && (|set_bits);
  assign addr_full = SUM_W'(px) + SUM_W'(page) * SUM_W'(PANEL_WIDTH);
  assign addr      = addr_full[ADDR_W-1:0];
endmodule
